@@ sv/bpl_pkg.sv @@
// Shared widths, codes and types for the paced byte loopback.
package bpl_pkg;

   localparam int TIME_W    = 32;
   localparam int PERIOD_W  = 24;
   localparam int BYTE_W    = 8;
   localparam int KIND_W    = 3;
   localparam int MODE_W    = 2;
   localparam int CSR_IDX_W = 4;
   localparam int REQ_W     = BYTE_W + TIME_W;

   localparam int SOURCE_DEPTH_DEF  = 64;
   localparam int RECEIVE_DEPTH_DEF = 8;

   localparam logic [KIND_W-1:0] KIND_WRITE = 3'd0;
   localparam logic [KIND_W-1:0] KIND_COUNT = 3'd1;
   localparam logic [KIND_W-1:0] KIND_READ  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_PEEK  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_FLUSH = 3'd4;

   localparam logic [MODE_W-1:0] MODE_IDLE  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PACED = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_LINK_MODE   = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BYTE_PERIOD = 4'd1;

   typedef struct packed {
      logic                done;
      logic [TIME_W-1:0]   quotient;
      logic [PERIOD_W-1:0] remainder;
   } div_result_type;

endpackage

@@ sv/baud_paced_byte_loopback.sv @@
// Paced byte loopback: source queue, receive queue and release sequencer.
//
// req channel: one transaction per access. req_tuser carries the kind (write,
// count, read, peek, flush); req_tdata carries the byte and the microsecond time.
// rsp channel: exactly one transaction per access, in order: byte, hit flag,
// write-accepted flag and the pending count after the access.
// csr channel: register writes (link mode, byte period); always ready. The user
// must only write it while no access is in flight; the block does not enforce it.
// An access without a release passes the operation and finish states before its
// result is registered for rsp. In paced mode, with bytes in the source queue,
// the divider first computes the 32-bit quotient of elapsed time by byte period,
// and each released byte then takes a source-memory read and a receive-memory
// write, at most RECEIVE_DEPTH bytes, as earlier ones would be overwritten.
// One access is in flight at a time.
// Reset empties both queues, zeroes the timer mark and selects the
// not-started mode; the memories need no clearing pass.
// A result waits in the rsp register while the receiver stalls; the next
// access is taken and held finished until that register frees up.
module baud_paced_byte_loopback #(
   parameter  int SOURCE_DEPTH  = bpl_pkg::SOURCE_DEPTH_DEF,
   parameter  int RECEIVE_DEPTH = bpl_pkg::RECEIVE_DEPTH_DEF,
   localparam int SCW    = $clog2(SOURCE_DEPTH + 1),
   localparam int RCW    = $clog2(RECEIVE_DEPTH + 1),
   localparam int PEND_W = (SCW > RCW) ? SCW : RCW,
   localparam int RSP_W  = ((bpl_pkg::BYTE_W + 1 + PEND_W + 7) / 8) * 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [bpl_pkg::REQ_W-1:0]      req_tdata,   // data_in, now_us
   input  logic [bpl_pkg::KIND_W-1:0]     req_tuser,   // kind
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [RSP_W-1:0]               rsp_tdata,   // data_out, write_accepted, pending_count
   output logic [0:0]                     rsp_tuser,   // data_valid
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [bpl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bpl_pkg::PERIOD_W-1:0]   csr_data
);
   import bpl_pkg::*;

   localparam int SAW = $clog2(SOURCE_DEPTH);
   localparam int RAW = (RECEIVE_DEPTH > 1) ? $clog2(RECEIVE_DEPTH) : 1;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_DIV   = 3'd1;
   localparam logic [2:0] ST_MV_RD = 3'd2;
   localparam logic [2:0] ST_MV_WR = 3'd3;
   localparam logic [2:0] ST_OP    = 3'd4;
   localparam logic [2:0] ST_FIN   = 3'd5;

   function automatic logic [SAW-1:0] src_wrap(input logic [SAW:0] sum);
      logic [SAW:0] adj;
      adj = (int'(sum) >= SOURCE_DEPTH) ? sum - (SAW+1)'(SOURCE_DEPTH) : sum;
      return adj[SAW-1:0];
   endfunction

   function automatic logic [RAW-1:0] rcv_wrap(input logic [RAW:0] sum);
      logic [RAW:0] adj;
      adj = (int'(sum) >= RECEIVE_DEPTH) ? sum - (RAW+1)'(RECEIVE_DEPTH) : sum;
      return adj[RAW-1:0];
   endfunction

   logic [2:0]          state_ff, state_in;
   logic [MODE_W-1:0]   mode_ff;
   logic [PERIOD_W-1:0] period_ff;
   logic [KIND_W-1:0]   kind_ff, kind_in;
   logic [BYTE_W-1:0]   din_ff, din_in;
   logic [TIME_W-1:0]   now_ff, now_in;
   logic [TIME_W-1:0]   mark_ff, mark_in;
   logic [SAW-1:0]      src_head_ff, src_head_in;
   logic [SCW-1:0]      src_cnt_ff, src_cnt_in;
   logic [RAW-1:0]      rcv_head_ff, rcv_head_in;
   logic [RCW-1:0]      rcv_cnt_ff, rcv_cnt_in;
   logic [SCW-1:0]      mv_left_ff, mv_left_in;
   logic                hit_ff, hit_in;
   logic                acc_ff, acc_in;
   logic                from_src_ff, from_src_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                rsp_hit_ff, rsp_hit_in;
   logic                rsp_acc_ff, rsp_acc_in;
   logic [PEND_W-1:0]   rsp_pend_ff, rsp_pend_in;

   logic [BYTE_W-1:0]   src_mem [SOURCE_DEPTH];
   logic [BYTE_W-1:0]   rcv_mem [RECEIVE_DEPTH];
   logic [BYTE_W-1:0]   src_rdata_ff, rcv_rdata_ff;
   logic                src_we, src_re, rcv_we, rcv_re;
   logic [SAW-1:0]      src_waddr, src_raddr;
   logic [RAW-1:0]      rcv_waddr, rcv_raddr;
   logic [BYTE_W-1:0]   src_wdata;

   logic                paced, free, accept, rel, upd_mark;
   logic                div_start;
   logic [PERIOD_W-1:0] div_divisor;
   div_result_type      div_res;
   logic [SCW-1:0]      mv_total, mv_keep, mv_skip;

   assign paced  = (mode_ff == MODE_PACED);
   assign free   = (mode_ff == MODE_FREE);
   assign accept = req_tvalid && req_tready;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;

   assign div_divisor = (period_ff == '0) ? PERIOD_W'(1) : period_ff;

   bpl_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (req_tdata[REQ_W-1:BYTE_W] - mark_ff),
      .divisor  (div_divisor),
      .result   (div_res)
   );

   always_comb begin
      rel      = paced && (src_cnt_ff != '0) && (req_tuser <= KIND_FLUSH);
      upd_mark = (req_tuser == KIND_WRITE) || (req_tuser == KIND_FLUSH) ||
                 (paced && (req_tuser >= KIND_COUNT) && (req_tuser <= KIND_PEEK));
      if (div_res.quotient < TIME_W'(src_cnt_ff)) begin
         mv_total = div_res.quotient[SCW-1:0];
      end else begin
         mv_total = src_cnt_ff;
      end
      mv_keep = (int'(mv_total) < RECEIVE_DEPTH) ? mv_total : SCW'(RECEIVE_DEPTH);
      mv_skip = mv_total - mv_keep;
   end

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      din_in       = din_ff;
      now_in       = now_ff;
      mark_in      = mark_ff;
      src_head_in  = src_head_ff;
      src_cnt_in   = src_cnt_ff;
      rcv_head_in  = rcv_head_ff;
      rcv_cnt_in   = rcv_cnt_ff;
      mv_left_in   = mv_left_ff;
      hit_in       = hit_ff;
      acc_in       = acc_ff;
      from_src_in  = from_src_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_acc_in   = rsp_acc_ff;
      rsp_pend_in  = rsp_pend_ff;
      div_start    = 1'b0;
      src_we       = 1'b0;
      src_re       = 1'b0;
      rcv_we       = 1'b0;
      rcv_re       = 1'b0;
      src_waddr    = src_wrap((SAW+1)'(src_head_ff) + (SAW+1)'(src_cnt_ff));
      src_raddr    = src_head_ff;
      src_wdata    = din_ff;
      rcv_waddr    = rcv_head_ff;
      rcv_raddr    = rcv_head_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in = req_tuser;
               din_in  = req_tdata[BYTE_W-1:0];
               now_in  = req_tdata[REQ_W-1:BYTE_W];
               if (rel) begin
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end else begin
                  if (upd_mark) begin
                     mark_in = req_tdata[REQ_W-1:BYTE_W];
                  end
                  state_in = ST_OP;
               end
            end
         end
         ST_DIV: begin
            if (div_res.done) begin
               mark_in     = now_ff - TIME_W'(div_res.remainder);
               src_head_in = src_wrap((SAW+1)'(src_head_ff) + (SAW+1)'(mv_skip));
               src_cnt_in  = src_cnt_ff - mv_skip;
               mv_left_in  = mv_keep;
               state_in    = (mv_keep != '0) ? ST_MV_RD : ST_OP;
            end
         end
         ST_MV_RD: begin
            src_re      = 1'b1;
            src_head_in = src_wrap((SAW+1)'(src_head_ff) + (SAW+1)'(1));
            src_cnt_in  = src_cnt_ff - SCW'(1);
            state_in    = ST_MV_WR;
         end
         ST_MV_WR: begin
            rcv_we = 1'b1;
            if (rcv_cnt_ff == RCW'(RECEIVE_DEPTH)) begin
               // full: overwrite the oldest byte
               rcv_head_in = rcv_wrap((RAW+1)'(rcv_head_ff) + (RAW+1)'(1));
            end else begin
               rcv_waddr  = rcv_wrap((RAW+1)'(rcv_head_ff) + (RAW+1)'(rcv_cnt_ff));
               rcv_cnt_in = rcv_cnt_ff + RCW'(1);
            end
            mv_left_in = mv_left_ff - SCW'(1);
            state_in   = (mv_left_ff == SCW'(1)) ? ST_OP : ST_MV_RD;
         end
         ST_OP: begin
            hit_in      = 1'b0;
            acc_in      = 1'b0;
            from_src_in = 1'b0;
            unique case (kind_ff)
               KIND_WRITE: begin
                  if (int'(src_cnt_ff) < SOURCE_DEPTH) begin
                     src_we     = 1'b1;
                     src_cnt_in = src_cnt_ff + SCW'(1);
                     acc_in     = 1'b1;
                  end
               end
               KIND_READ, KIND_PEEK: begin
                  if (free && (src_cnt_ff != '0)) begin
                     src_re      = 1'b1;
                     hit_in      = 1'b1;
                     from_src_in = 1'b1;
                     if (kind_ff == KIND_READ) begin
                        src_head_in = src_wrap((SAW+1)'(src_head_ff) + (SAW+1)'(1));
                        src_cnt_in  = src_cnt_ff - SCW'(1);
                     end
                  end else if (paced && (rcv_cnt_ff != '0)) begin
                     rcv_re = 1'b1;
                     hit_in = 1'b1;
                     if (kind_ff == KIND_READ) begin
                        rcv_head_in = rcv_wrap((RAW+1)'(rcv_head_ff) + (RAW+1)'(1));
                        rcv_cnt_in  = rcv_cnt_ff - RCW'(1);
                     end
                  end
               end
               default: begin
               end
            endcase
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = hit_ff;
               rsp_acc_in   = acc_ff;
               if (!hit_ff) begin
                  rsp_data_in = '0;
               end else begin
                  rsp_data_in = from_src_ff ? src_rdata_ff : rcv_rdata_ff;
               end
               if (paced) begin
                  rsp_pend_in = PEND_W'(rcv_cnt_ff);
               end else if (free) begin
                  rsp_pend_in = PEND_W'(src_cnt_ff);
               end else begin
                  rsp_pend_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_IDLE;
         period_ff    <= PERIOD_W'(1);
         mark_ff      <= '0;
         src_head_ff  <= '0;
         src_cnt_ff   <= '0;
         rcv_head_ff  <= '0;
         rcv_cnt_ff   <= '0;
         mv_left_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mark_ff      <= mark_in;
         src_head_ff  <= src_head_in;
         src_cnt_ff   <= src_cnt_in;
         rcv_head_ff  <= rcv_head_in;
         rcv_cnt_ff   <= rcv_cnt_in;
         mv_left_ff   <= mv_left_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_LINK_MODE) begin
               mode_ff <= csr_data[MODE_W-1:0];
            end else if (csr_index == CSR_BYTE_PERIOD) begin
               period_ff <= csr_data;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      din_ff      <= din_in;
      now_ff      <= now_in;
      hit_ff      <= hit_in;
      acc_ff      <= acc_in;
      from_src_ff <= from_src_in;
      rsp_data_ff <= rsp_data_in;
      rsp_hit_ff  <= rsp_hit_in;
      rsp_acc_ff  <= rsp_acc_in;
      rsp_pend_ff <= rsp_pend_in;
   end

   always_ff @(posedge clock) begin
      if (src_we) begin
         src_mem[src_waddr] <= src_wdata;
      end
      if (src_re) begin
         src_rdata_ff <= src_mem[src_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (rcv_we) begin
         rcv_mem[rcv_waddr] <= src_rdata_ff;
      end
      if (rcv_re) begin
         rcv_rdata_ff <= rcv_mem[rcv_raddr];
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = RSP_W'({rsp_pend_ff, rsp_acc_ff, rsp_data_ff});
   assign rsp_tuser[0] = rsp_hit_ff;

   a_src_bound: assert property (@(posedge clock) disable iff (reset)
      int'(src_cnt_ff) <= SOURCE_DEPTH)
      else $error("source count beyond depth");

   a_rcv_bound: assert property (@(posedge clock) disable iff (reset)
      int'(rcv_cnt_ff) <= RECEIVE_DEPTH)
      else $error("receive count beyond depth");

   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_res.done |-> (state_ff == ST_DIV))
      else $error("divider finished outside release");

   a_hit_vs_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_hit_ff && rsp_acc_ff))
      else $error("result both returns a byte and accepts a write");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != ST_IDLE))
      else $error("transaction accepted without leaving idle");

endmodule

@@ sv/bpl_div.sv @@
// Restoring divider, elapsed time by byte period, one quotient bit per cycle.
module bpl_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [bpl_pkg::TIME_W-1:0]    dividend,
   input  logic [bpl_pkg::PERIOD_W-1:0]  divisor,
   output bpl_pkg::div_result_type       result
);
   import bpl_pkg::*;

   localparam int STEP_W = $clog2(TIME_W);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [TIME_W-1:0]   quo_ff, quo_in;
   logic [PERIOD_W-1:0] acc_ff, acc_in;
   logic [PERIOD_W-1:0] dvs_ff, dvs_in;
   logic [PERIOD_W:0]   trial;

   always_comb begin
      trial   = {acc_ff, quo_ff[TIME_W-1]} - {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      acc_in  = acc_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         quo_in  = dividend;
         acc_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (!trial[PERIOD_W]) begin
            acc_in = trial[PERIOD_W-1:0];
            quo_in = {quo_ff[TIME_W-2:0], 1'b1};
         end else begin
            acc_in = {acc_ff[PERIOD_W-2:0], quo_ff[TIME_W-1]};
            quo_in = {quo_ff[TIME_W-2:0], 1'b0};
         end
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(TIME_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      acc_ff <= acc_in;
      dvs_ff <= dvs_in;
   end

   assign result.done      = done_ff;
   assign result.quotient  = quo_ff;
   assign result.remainder = acc_ff;

endmodule

@@ tb/baud_paced_byte_loopback_tb.sv @@
// Self-checking testbench for the paced byte loopback: directed and random accesses.
`timescale 1ns / 1ps

module baud_paced_byte_loopback_tb;
   import bpl_pkg::*;

   localparam int PHASES = 12;
   localparam int PHASE_ITEMS = 70;
   localparam int RSP_W = 16;
   localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
   localparam logic [KIND_W-1:0] KIND_RSVD_LO = 3'd5;
   localparam logic [KIND_W-1:0] KIND_RSVD_HI = 3'd7;

   class link_scoreboard;
      typedef struct packed {
         logic [BYTE_W-1:0] data_out;
         logic              hit;
         logic              accepted;
         logic [6:0]        pending;
      } reply_type;

      logic [BYTE_W-1:0]   src_mem [SOURCE_DEPTH_DEF];
      int unsigned         src_head;
      int unsigned         src_count;
      logic [BYTE_W-1:0]   rx_mem [RECEIVE_DEPTH_DEF];
      int unsigned         rx_head;
      int unsigned         rx_count;
      logic [TIME_W-1:0]   mark;
      logic [MODE_W-1:0]   mode;
      logic [PERIOD_W-1:0] period;
      reply_type           owed_replies [$];
      int unsigned         faults;

      function new();
         src_head  = 0;
         src_count = 0;
         rx_head   = 0;
         rx_count  = 0;
         mark      = '0;
         mode      = MODE_IDLE;
         period    = 1;
         faults    = 0;
      endfunction

      function void note_reg(logic [CSR_IDX_W-1:0] idx, logic [PERIOD_W-1:0] value);
         if (idx == CSR_LINK_MODE) begin
            mode = value[MODE_W-1:0];
         end else if (idx == CSR_BYTE_PERIOD) begin
            period = value;
         end
      endfunction

      // moves bytes due since the mark into the receive queue, returns the leftover time
      function logic [TIME_W-1:0] move_due_bytes(logic [TIME_W-1:0] now);
         logic [TIME_W-1:0] per;
         logic [TIME_W-1:0] elapsed;
         logic [TIME_W-1:0] n;
         if (mode != MODE_PACED || src_count == 0) return '0;
         per = (period == '0) ? 1 : period;
         elapsed = now - mark;
         n = elapsed / per;
         if (n == 0) return elapsed;
         elapsed = elapsed - n * per;
         if (n > src_count) n = src_count;
         repeat (n) begin
            if (rx_count >= RECEIVE_DEPTH_DEF) begin
               rx_head = (rx_head + 1) % RECEIVE_DEPTH_DEF;
               rx_count--;
            end
            rx_mem[(rx_head + rx_count) % RECEIVE_DEPTH_DEF] = src_mem[src_head];
            rx_count++;
            src_head = (src_head + 1) % SOURCE_DEPTH_DEF;
            src_count--;
         end
         return elapsed;
      endfunction

      function void note_access(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] data,
                                logic [TIME_W-1:0] now);
         reply_type         reply;
         logic [TIME_W-1:0] rem;
         reply = '0;
         if (kind == KIND_WRITE || kind == KIND_FLUSH) begin
            rem = move_due_bytes(now);
            if (kind == KIND_WRITE && src_count < SOURCE_DEPTH_DEF) begin
               src_mem[(src_head + src_count) % SOURCE_DEPTH_DEF] = data;
               src_count++;
               reply.accepted = 1'b1;
            end
            mark = now - rem;
         end else if (kind == KIND_COUNT || kind == KIND_READ || kind == KIND_PEEK) begin
            if (mode == MODE_FREE) begin
               if (kind != KIND_COUNT && src_count > 0) begin
                  reply.data_out = src_mem[src_head];
                  reply.hit = 1'b1;
                  if (kind == KIND_READ) begin
                     src_head = (src_head + 1) % SOURCE_DEPTH_DEF;
                     src_count--;
                  end
               end
            end else if (mode == MODE_PACED) begin
               rem = move_due_bytes(now);
               if (kind != KIND_COUNT && rx_count > 0) begin
                  reply.data_out = rx_mem[rx_head];
                  reply.hit = 1'b1;
                  if (kind == KIND_READ) begin
                     rx_head = (rx_head + 1) % RECEIVE_DEPTH_DEF;
                     rx_count--;
                  end
               end
               mark = now - rem;
            end
         end
         if (mode == MODE_PACED) begin
            reply.pending = rx_count;
         end else if (mode == MODE_FREE) begin
            reply.pending = src_count;
         end
         owed_replies.push_back(reply);
      endfunction

      function void check_result(logic [BYTE_W-1:0] data_out, logic hit, logic accepted,
                                 logic [6:0] pending);
         reply_type want;
         if (owed_replies.size() == 0) begin
            faults++;
            if (faults <= 10)
               $display("%0t: unexpected reply data %h hit %b acc %b pend %0d",
                        $time, data_out, hit, accepted, pending);
            return;
         end
         want = owed_replies.pop_front();
         if (data_out !== want.data_out || hit !== want.hit || accepted !== want.accepted
             || pending !== want.pending) begin
            faults++;
            if (faults <= 10)
               $display("%0t: mismatch exp data %h hit %b acc %b pend %0d, got %h %b %b %0d",
                        $time, want.data_out, want.hit, want.accepted, want.pending,
                        data_out, hit, accepted, pending);
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tdata = '0;
   logic [KIND_W-1:0]     req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_W-1:0]      rsp_tdata;
   logic [0:0]            rsp_tuser;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [PERIOD_W-1:0]   csr_data = '0;

   link_scoreboard sb = new();
   int unsigned gap_pct = 0;
   int unsigned stall_pct = 0;
   logic [TIME_W-1:0] link_time = '0;

   logic [MODE_W-1:0] phase_mode [PHASES] = '{MODE_PACED, MODE_FREE, MODE_PACED, MODE_PACED,
                                             MODE_IDLE, MODE_SPARE, MODE_PACED, MODE_PACED,
                                             MODE_FREE, MODE_PACED, MODE_PACED, MODE_PACED};
   int phase_period [PHASES] = '{3, 5, 1, 16777215, 9, 2, -1, 0, 4, 7, 2, 11};
   int phase_write_pct [PHASES] = '{45, 70, 50, 60, 45, 45, 45, 50, 40, 45, 55, 45};

   baud_paced_byte_loopback dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("baud_paced_byte_loopback_tb: FAIL");
      $finish;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready)
         sb.check_result(rsp_tdata[7:0], rsp_tuser[0], rsp_tdata[8], rsp_tdata[15:9]);
   end

   task automatic send_access(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] data,
                              input logic [TIME_W-1:0] now);
      while ($urandom_range(0, 99) < gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {now, data};
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      sb.note_access(kind, data, now);
   endtask

   task automatic drain_replies();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.owed_replies.size() != 0);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [PERIOD_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      sb.note_reg(idx, value);
   endtask

   // registers change only with nothing in flight
   task automatic apply_settings(input logic [MODE_W-1:0] mode, input logic [PERIOD_W-1:0] per);
      drain_replies();
      write_reg(CSR_BYTE_PERIOD, per);
      if ($urandom_range(0, 2) == 0)
         write_reg(CSR_IDX_W'($urandom_range(CSR_BYTE_PERIOD + 1, 2 ** CSR_IDX_W - 1)),
                   PERIOD_W'($urandom()));
      write_reg(CSR_LINK_MODE, {(PERIOD_W - MODE_W)'($urandom()), mode});
      csr_valid <= 1'b0;
   endtask

   function automatic void advance_link_time(int unsigned per);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 3)
         link_time = $urandom();
      else if (r < 5)
         link_time = 32'hFFFF_FFC0 + $urandom_range(0, 63);
      else if (r < 22)
         link_time += $urandom_range(0, 20 * per);
      else if (r < 88)
         link_time += $urandom_range(0, 3 * per);
   endfunction

   function automatic logic [KIND_W-1:0] pick_kind(int unsigned write_pct);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 3) return KIND_W'($urandom_range(KIND_RSVD_LO, KIND_RSVD_HI));
      if (r < 3 + write_pct) return KIND_WRITE;
      return KIND_W'(KIND_COUNT + $urandom_range(0, 3));
   endfunction

   initial begin
      int per;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // not started: writes still land in the source queue, lookups report nothing
      send_access(KIND_WRITE, 8'hA5, 32'd100);
      send_access(KIND_COUNT, 8'h00, 32'd150);
      send_access(KIND_READ, 8'h00, 32'd160);
      send_access(KIND_PEEK, 8'h00, 32'd170);
      send_access(KIND_RSVD_LO, 8'hFF, 32'd180);
      send_access(KIND_FLUSH, 8'h00, 32'd200);

      // unlimited rate: lookups act on the source queue
      apply_settings(MODE_FREE, 24'd1);
      send_access(KIND_WRITE, 8'h00, 32'd0);
      send_access(KIND_WRITE, 8'hFF, 32'hFFFF_FFFF);
      send_access(KIND_PEEK, 8'h5A, 32'd10);
      send_access(KIND_COUNT, 8'h00, 32'd10);
      repeat (4) send_access(KIND_READ, 8'h00, 32'd20);
      send_access(KIND_RSVD_HI, 8'h81, 32'd30);

      // paced, zero period behaves as one
      apply_settings(MODE_PACED, 24'd0);
      send_access(KIND_WRITE, 8'h3C, 32'd1000);
      send_access(KIND_WRITE, 8'hC3, 32'd1000);
      send_access(KIND_COUNT, 8'h00, 32'd1000);
      send_access(KIND_COUNT, 8'h00, 32'd1001);
      send_access(KIND_PEEK, 8'h00, 32'd1001);
      send_access(KIND_READ, 8'h00, 32'd1001);
      send_access(KIND_FLUSH, 8'h00, 32'd1003);
      send_access(KIND_READ, 8'h00, 32'd1003);
      send_access(KIND_PEEK, 8'h00, 32'd1003);
      link_time = 32'd1003;

      for (int p = 0; p < PHASES; p++) begin
         per = (phase_period[p] < 0) ? $urandom_range(1, 40) : phase_period[p];
         apply_settings(phase_mode[p], PERIOD_W'(per));
         case (p % 4)
            0: begin
               gap_pct = 0;
               stall_pct = 0;
            end
            1: begin
               gap_pct = 72;
               stall_pct = 0;
            end
            2: begin
               gap_pct = 0;
               stall_pct = 72;
            end
            default: begin
               gap_pct = 28;
               stall_pct = 28;
            end
         endcase
         if (per == 0) per = 1;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if ($urandom_range(0, 39) == 0) drain_replies();
            advance_link_time(per);
            send_access(pick_kind(phase_write_pct[p]), BYTE_W'($urandom_range(0, 255)),
                        link_time);
         end
      end

      drain_replies();
      repeat (60) @(posedge clock);
      if (sb.faults == 0 && sb.owed_replies.size() == 0)
         $display("baud_paced_byte_loopback_tb: PASS");
      else
         $display("baud_paced_byte_loopback_tb: FAIL");
      $finish;
   end

endmodule

@@ filelist.f @@
sv/bpl_pkg.sv
sv/bpl_div.sv
sv/baud_paced_byte_loopback.sv
tb/baud_paced_byte_loopback_tb.sv
